FILE: hw/rtl/wwas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Weighted window average package
// Shared types, register codes and constants of the weighted window average.
// ----------------------------------------------------------------------------
package wwas_pkg;

    localparam int WINDOW_MAX_DEF = 64;

    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam logic [16:0] WEIGHT_RST  = 17'd58982;
    localparam logic [30:0] THRESH_RST  = 31'd0;
    localparam logic [6:0]  WSIZE_RST   = 7'd16;

    localparam logic signed [31:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAMPLE_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        REG_WEIGHT      = 2'd0,
        REG_THRESHOLD   = 2'd1,
        REG_WINDOW_SIZE = 2'd2
    } reg_index_t;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic               operation;
        logic signed [31:0] sample;
    } wwas_in_t;

    typedef struct packed {
        logic signed [31:0] average;
        logic               stable;
        logic signed [31:0] minimum;
        logic signed [31:0] maximum;
        logic [6:0]         fill_count;
    } wwas_out_t;

    typedef struct packed {
        logic init;
        logic mul_sample;
        logic mul_weight;
        logic load_wk;
    } mac_ctrl_t;

endpackage
`default_nettype wire

FILE: hw/rtl/wwas_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wwas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/wwas_mac.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Weighted multiply-accumulate unit
// One shared multiplier forms sample*w^k and the next power w^(k+1);
// accumulates the weighted sum, the weight sum, and the sample extremes.
// ----------------------------------------------------------------------------
module wwas_mac #(
    parameter int WINDOW_MAX = wwas_pkg::WINDOW_MAX_DEF,
    localparam int LW  = $clog2(WINDOW_MAX + 1),
    localparam int VW  = 48 + LW,
    localparam int WSW = 17 + LW
) (
    input  wire logic                      aclk,
    input  wire wwas_pkg::mac_ctrl_t       ctrl,
    input  wire logic signed [31:0]        sample,
    input  wire logic        [16:0]        weight,
    output logic signed      [VW-1:0]      vsum,
    output logic             [WSW-1:0]     wsum,
    output logic signed      [31:0]        minimum,
    output logic signed      [31:0]        maximum
);
    import wwas_pkg::*;

    logic        [16:0]    wk_reg;
    logic signed [50:0]    prod_reg;
    logic signed [VW-1:0]  vsum_reg;
    logic        [WSW-1:0] wsum_reg;
    logic signed [31:0]    min_reg;
    logic signed [31:0]    max_reg;

    logic signed [32:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [50:0] mul_p;

    always_comb begin
        if (ctrl.mul_sample) begin
            mul_a = {sample[31], sample};
            mul_b = {1'b0, wk_reg};
        end else begin
            mul_a = {16'd0, wk_reg};
            mul_b = {1'b0, weight};
        end
        mul_p = mul_a * mul_b;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.init) begin
            wk_reg   <= ONE_Q16;
            vsum_reg <= '0;
            wsum_reg <= '0;
            min_reg  <= SAMPLE_MAX;
            max_reg  <= SAMPLE_MIN;
        end
        if (ctrl.mul_sample) begin
            prod_reg <= mul_p;
            wsum_reg <= wsum_reg + WSW'(wk_reg);
            if (sample < min_reg) begin
                min_reg <= sample;
            end
            if (sample > max_reg) begin
                max_reg <= sample;
            end
        end
        if (ctrl.mul_weight) begin
            prod_reg <= mul_p;
            vsum_reg <= vsum_reg + VW'(prod_reg);
        end
        if (ctrl.load_wk) begin
            wk_reg <= prod_reg[32:16];
        end
    end

    assign vsum    = vsum_reg;
    assign wsum    = wsum_reg;
    assign minimum = min_reg;
    assign maximum = max_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/wwas_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Restoring divider
// Signed weighted sum over unsigned weight sum, one quotient bit per cycle,
// 32 quotient bits, truncated toward zero.
// ----------------------------------------------------------------------------
module wwas_div #(
    parameter int WINDOW_MAX = wwas_pkg::WINDOW_MAX_DEF,
    localparam int LW  = $clog2(WINDOW_MAX + 1),
    localparam int DW  = 48 + LW,
    localparam int WSW = 17 + LW
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic signed [DW-1:0]  dividend,
    input  wire logic        [WSW-1:0] divisor,
    output logic                       done,
    output logic signed      [31:0]    quotient
);
    import wwas_pkg::*;

    logic          busy_reg;
    logic          done_reg;
    logic [4:0]    cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] dsh_reg;
    logic [31:0]   q_reg;
    logic          neg_reg;

    logic [DW-1:0] mag;
    logic          fits;

    assign mag  = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
    assign fits = rem_reg >= dsh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == 5'd0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= mag;
            dsh_reg <= {divisor, 31'd0};
            cnt_reg <= 5'd31;
            neg_reg <= dividend[DW-1];
            q_reg   <= '0;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            q_reg   <= {q_reg[30:0], fits};
            dsh_reg <= dsh_reg >> 1;
            cnt_reg <= cnt_reg - 5'd1;
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(q_reg) : $signed(q_reg);

endmodule
`default_nettype wire

FILE: hw/rtl/weighted_window_average_stability.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Weighted window average with stability flag
// Push: the result follows one pass and one divide over the held samples while
// the window fills; once full, it follows two passes and two divides.
// Clear: goes straight to the finish state. New requests are taken only in idle.
// Each pass steps every sample through MUL_S, MUL_W and WK on the one shared
// multiplier. A report still held at the output stalls the sequencer.
// Synchronous active-low reset empties the window and loads register defaults.
// ----------------------------------------------------------------------------
module weighted_window_average_stability #(
    parameter int WINDOW_MAX = wwas_pkg::WINDOW_MAX_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire wwas_pkg::wwas_in_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output wwas_pkg::wwas_out_t      m_data,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import wwas_pkg::*;

    localparam int LW  = $clog2(WINDOW_MAX + 1);
    localparam int CW  = LW;
    localparam int AW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int VW  = 48 + LW;
    localparam int WSW = 17 + LW;

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_APPEND   = 10'b00_0000_0010,
        ST_INIT     = 10'b00_0000_0100,
        ST_MUL_S    = 10'b00_0000_1000,
        ST_MUL_W    = 10'b00_0001_0000,
        ST_WK       = 10'b00_0010_0000,
        ST_DIV_WAIT = 10'b00_0100_0000,
        ST_DROP     = 10'b00_1000_0000,
        ST_FINISH   = 10'b01_0000_0000,
        ST_SPARE    = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [16:0] weight_reg;
    logic [30:0] thresh_reg;
    logic [6:0]  wsize_reg;

    logic [CW-1:0] fill_reg, fill_next;
    logic [AW-1:0] oldest_reg, oldest_next;
    logic [CW-1:0] off_reg, off_next;
    logic          done_reg, done_next;
    logic          full_reg, full_next;
    logic          second_reg, second_next;
    logic          stable_reg, stable_next;
    logic signed [31:0] avg_reg, avg_next;
    logic signed [31:0] old_avg_reg, old_avg_next;
    logic signed [31:0] sample_reg;
    logic          m_valid_reg, m_valid_next;
    wwas_out_t     m_data_reg, m_data_next;

    logic [CW-1:0] eff_size;
    logic [16:0]   w_sat;
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   ram_rdata;
    mac_ctrl_t     mac_ctrl;
    logic signed [VW-1:0] vsum;
    logic [WSW-1:0] wsum;
    logic signed [31:0] mac_min, mac_max;
    logic          div_start, div_done;
    logic signed [31:0] div_q;
    logic signed [32:0] avg_diff;
    logic [32:0]   diff_mag;
    logic          stable_cmp;
    logic          s_fire;

    function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                           input logic [CW-1:0] offset);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(offset);
        if (sum >= (CW+1)'(WINDOW_MAX)) begin
            sum = sum - (CW+1)'(WINDOW_MAX);
        end
        return AW'(sum);
    endfunction

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg <= WEIGHT_RST;
            thresh_reg <= THRESH_RST;
            wsize_reg  <= WSIZE_RST;
        end else if (psel && penable && pwrite) begin
            unique case (reg_index_t'(paddr[3:2]))
                REG_WEIGHT:      weight_reg <= pwdata[16:0];
                REG_THRESHOLD:   thresh_reg <= pwdata[30:0];
                REG_WINDOW_SIZE: wsize_reg  <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index_t'(paddr[3:2]))
            REG_WEIGHT:      prdata = {15'd0, weight_reg};
            REG_THRESHOLD:   prdata = {1'b0, thresh_reg};
            REG_WINDOW_SIZE: prdata = {25'd0, wsize_reg};
            default:         prdata = 32'd0;
        endcase
    end

    always_comb begin
        if (wsize_reg == 7'd0) begin
            eff_size = CW'(1);
        end else if (32'(wsize_reg) > 32'(WINDOW_MAX)) begin
            eff_size = CW'(WINDOW_MAX);
        end else begin
            eff_size = CW'(wsize_reg);
        end
        w_sat = (weight_reg > ONE_Q16) ? ONE_Q16 : weight_reg;
    end

    assign avg_diff   = {old_avg_reg[31], old_avg_reg} - {avg_reg[31], avg_reg};
    assign diff_mag   = avg_diff[32] ? 33'(-avg_diff) : 33'(avg_diff);
    assign stable_cmp = diff_mag < {2'd0, thresh_reg};

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        oldest_next  = oldest_reg;
        off_next     = off_reg;
        done_next    = done_reg;
        full_next    = full_reg;
        second_next  = second_reg;
        stable_next  = stable_reg;
        avg_next     = avg_reg;
        old_avg_next = old_avg_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_waddr    = slot(oldest_reg, fill_reg);
        ram_re       = 1'b0;
        ram_raddr    = slot(oldest_reg, off_reg - CW'(1));
        mac_ctrl     = '0;
        div_start    = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_data.operation == OP_CLEAR) begin
                        fill_next   = '0;
                        oldest_next = '0;
                        stable_next = 1'b0;
                        avg_next    = '0;
                        state_next  = ST_FINISH;
                    end else if (fill_reg < eff_size) begin
                        full_next   = 1'b0;
                        second_next = 1'b1;
                        stable_next = 1'b0;
                        state_next  = ST_APPEND;
                    end else begin
                        full_next   = 1'b1;
                        second_next = 1'b0;
                        state_next  = ST_INIT;
                    end
                end
            end
            ST_APPEND: begin
                ram_we     = 1'b1;
                fill_next  = fill_reg + CW'(1);
                state_next = ST_INIT;
            end
            ST_INIT: begin
                mac_ctrl.init = 1'b1;
                ram_re        = 1'b1;
                ram_raddr     = slot(oldest_reg, fill_reg - CW'(1));
                off_next      = fill_reg - CW'(1);
                state_next    = ST_MUL_S;
            end
            ST_MUL_S: begin
                mac_ctrl.mul_sample = 1'b1;
                state_next          = ST_MUL_W;
            end
            ST_MUL_W: begin
                mac_ctrl.mul_weight = 1'b1;
                done_next           = (off_reg == '0);
                if (off_reg != '0) begin
                    ram_re   = 1'b1;
                    off_next = off_reg - CW'(1);
                end
                state_next = ST_WK;
            end
            ST_WK: begin
                mac_ctrl.load_wk = 1'b1;
                if (done_reg) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_WAIT;
                end else begin
                    state_next = ST_MUL_S;
                end
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    if (second_reg) begin
                        avg_next   = div_q;
                        state_next = ST_FINISH;
                    end else begin
                        old_avg_next = div_q;
                        state_next   = ST_DROP;
                    end
                end
            end
            ST_DROP: begin
                oldest_next = slot(oldest_reg, fill_reg - eff_size + CW'(1));
                fill_next   = eff_size - CW'(1);
                second_next = 1'b1;
                state_next  = ST_APPEND;
            end
            ST_FINISH: begin
                if (full_reg && second_reg) begin
                    stable_next = stable_cmp;
                end
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_data_next.average    = avg_reg;
                    m_data_next.stable     = (full_reg && second_reg) ? stable_cmp
                                                                      : stable_reg;
                    m_data_next.minimum    = (fill_reg == '0) ? SAMPLE_MAX : mac_min;
                    m_data_next.maximum    = (fill_reg == '0) ? SAMPLE_MIN : mac_max;
                    m_data_next.fill_count = 7'(fill_reg);
                    full_next              = 1'b0;
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            oldest_reg  <= '0;
            stable_reg  <= 1'b0;
            full_reg    <= 1'b0;
            second_reg  <= 1'b0;
            done_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            oldest_reg  <= oldest_next;
            stable_reg  <= stable_next;
            full_reg    <= full_next;
            second_reg  <= second_next;
            done_reg    <= done_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        off_reg     <= off_next;
        avg_reg     <= avg_next;
        old_avg_reg <= old_avg_next;
        m_data_reg  <= m_data_next;
        if (s_fire) begin
            sample_reg <= s_data.sample;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    wwas_ram #(
        .WIDTH (32),
        .DEPTH (WINDOW_MAX)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (sample_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    wwas_mac #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_mac (
        .aclk    (aclk),
        .ctrl    (mac_ctrl),
        .sample  ($signed(ram_rdata)),
        .weight  (w_sat),
        .vsum    (vsum),
        .wsum    (wsum),
        .minimum (mac_min),
        .maximum (mac_max)
    );

    wwas_div #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (vsum),
        .divisor  (wsum),
        .done     (div_done),
        .quotient (div_q)
    );

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(fill_reg) <= 32'(WINDOW_MAX))
        else $error("fill level above window depth");

    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV_WAIT)
        else $error("divide finished outside of wait state");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_ready)
        else $error("request accepted while previous one in flight");

    a_stable_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && stable_reg) |-> fill_reg != '0)
        else $error("stable flag set on empty window");

endmodule
`default_nettype wire
